@@ rtl/lfu_page_replacement_top_defines.svh @@
// Assertion macros used by the LFU replacement top
`ifndef LFU_PAGE_REPLACEMENT_TOP_DEFINES_SVH
`define LFU_PAGE_REPLACEMENT_TOP_DEFINES_SVH

// Checked on every clock edge outside reset
`define LFU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included
`define LFU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/lfu_pkg.sv @@
package lfu_pkg;

  localparam int NUM_FRAMES = 16;
  localparam int PAGE_BITS  = 16;
  localparam int IDX_W      = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int ACT_W      = $clog2(NUM_FRAMES + 1);
  localparam int CNT_W      = 16;
  localparam int FAULT_W    = 32;
  localparam int CFG_W      = 5;

  // Search token handed from cell to cell
  typedef struct packed {
    logic                 vld;
    logic [PAGE_BITS-1:0] page;
    logic                 found;
    logic [IDX_W-1:0]     match_idx;
    logic                 have_empty;
    logic [IDX_W-1:0]     empty_idx;
    logic [CNT_W-1:0]     min_cnt;
    logic [IDX_W-1:0]     min_idx;
    logic [PAGE_BITS-1:0] min_page;
  } scan_t;

  // Frame update broadcast to all cells
  typedef struct packed {
    logic                 en;
    logic                 load;
    logic [IDX_W-1:0]     idx;
    logic [PAGE_BITS-1:0] page;
  } wr_t;

endpackage

@@ rtl/lfu_cell.sv @@
module lfu_cell (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [lfu_pkg::IDX_W-1:0] cell_idx,
  input  logic                    active,
  input  lfu_pkg::scan_t          scan_in,
  output lfu_pkg::scan_t          scan_out,
  input  lfu_pkg::wr_t            wr
);
  import lfu_pkg::*;

  logic [PAGE_BITS-1:0] page_r;
  logic                 valid_r;
  logic [CNT_W-1:0]     cnt_r;
  scan_t                scan_r;
  scan_t                scan_nxt;

  // Fold this frame into the passing search token
  always_comb begin
    scan_nxt = scan_in;
    if (active) begin
      if (!scan_in.found && valid_r && (page_r == scan_in.page)) begin
        scan_nxt.found     = 1'b1;
        scan_nxt.match_idx = cell_idx;
      end
      if (!scan_in.have_empty && !valid_r) begin
        scan_nxt.have_empty = 1'b1;
        scan_nxt.empty_idx  = cell_idx;
      end
      // frame 0 always seeds the minimum; later frames need a strictly smaller count
      if ((cell_idx == '0) || (cnt_r < scan_in.min_cnt)) begin
        scan_nxt.min_cnt  = cnt_r;
        scan_nxt.min_idx  = cell_idx;
        scan_nxt.min_page = page_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r <= '0;
    end else begin
      scan_r <= scan_nxt;
    end
  end

  // Frame contents: load on a fault, count up on a hit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      page_r  <= '0;
      cnt_r   <= '0;
    end else if (wr.en && (wr.idx == cell_idx)) begin
      if (wr.load) begin
        page_r  <= wr.page;
        valid_r <= 1'b1;
        cnt_r   <= CNT_W'(1);
      end else if (cnt_r != '1) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

  assign scan_out = scan_r;

endmodule

@@ rtl/lfu_page_replacement_top.sv @@
// Channel   Direction  Handshake            Payload
// input     in         start / busy         in_page_number
// result    out        out_valid (strobe)   out_hit, out_frame_index, out_evicted_valid,
//                                           out_evicted_page, out_fault_total
// config    in         cfg_we               cfg_wdata (frames_in_use)
//
// A reference walks the row of frame cells one cell per clock; the result strobe follows once
// the token has left the last cell and been registered.
// busy drops in the strobe cycle, so the next reference can be taken as soon as the result
// strobe shows; no new reference is taken while one is in flight.
// Synchronous active-low reset empties all frames, clears the fault total and sets
// frames_in_use to 16. The receiver cannot stall: each result shows for one cycle only.
`include "lfu_page_replacement_top_defines.svh"

module lfu_page_replacement_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_page_number,
  output logic        out_valid,
  output logic        out_hit,
  output logic [3:0]  out_frame_index,
  output logic        out_evicted_valid,
  output logic [15:0] out_evicted_page,
  output logic [31:0] out_fault_total,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata
);
  import lfu_pkg::*;

  logic [CFG_W-1:0]          cfg_r;
  logic                      busy_r;
  scan_t                     tok_r;
  scan_t                     tok_nxt;
  scan_t                     chain [0:NUM_FRAMES];
  scan_t                     fin;
  wr_t                       wr;
  logic [ACT_W-1:0]          n_act;
  logic [NUM_FRAMES-1:0]     active;
  logic [NUM_FRAMES:0]       tok_vlds;
  logic [FAULT_W-1:0]        fault_r;
  logic [FAULT_W-1:0]        fault_nxt;
  logic                      accept;
  logic                      hit;
  logic                      evicted;
  logic [IDX_W-1:0]          slot;
  logic [PAGE_BITS+15:0]     page_ext;
  logic [PAGE_BITS+15:0]     ev_ext;
  logic [IDX_W+3:0]          slot_ext;
  logic                      out_valid_r;
  logic                      out_hit_r;
  logic [3:0]                out_frame_index_r;
  logic                      out_evicted_valid_r;
  logic [15:0]               out_evicted_page_r;

  assign accept = start && !busy_r;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_W'(16);
    end else if (cfg_we) begin
      cfg_r <= cfg_wdata;
    end
  end

  // Clamp active frame count to 1 .. NUM_FRAMES
  always_comb begin
    if (cfg_r == '0) begin
      n_act = ACT_W'(1);
    end else if (32'(cfg_r) > 32'(NUM_FRAMES)) begin
      n_act = ACT_W'(NUM_FRAMES);
    end else begin
      n_act = ACT_W'(cfg_r);
    end
  end

  // Seed token for a new transaction
  assign page_ext = {16'b0, in_page_number};
  always_comb begin
    tok_nxt            = '0;
    tok_nxt.vld        = accept;
    tok_nxt.page       = page_ext[PAGE_BITS-1:0];
    tok_nxt.min_cnt    = '1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign chain[0] = tok_r;

  // Row of frame cells
  for (genvar i = 0; i < NUM_FRAMES; i++) begin : g_cell
    assign active[i] = (32'(i) < 32'(n_act));
    lfu_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(i)),
      .active   (active[i]),
      .scan_in  (chain[i]),
      .scan_out (chain[i+1]),
      .wr       (wr)
    );
  end

  for (genvar i = 0; i <= NUM_FRAMES; i++) begin : g_vld
    assign tok_vlds[i] = chain[i].vld;
  end

  // Decision once the token leaves the last cell
  assign fin     = chain[NUM_FRAMES];
  assign hit     = fin.found;
  assign evicted = !fin.found && !fin.have_empty;
  always_comb begin
    if (fin.found) begin
      slot = fin.match_idx;
    end else if (fin.have_empty) begin
      slot = fin.empty_idx;
    end else begin
      slot = fin.min_idx;
    end
  end

  assign wr.en   = fin.vld;
  assign wr.load = !fin.found;
  assign wr.idx  = slot;
  assign wr.page = fin.page;

  assign fault_nxt = (fin.vld && !hit && (fault_r != '1)) ? fault_r + FAULT_W'(1) : fault_r;
  assign slot_ext  = {4'b0, slot};
  assign ev_ext    = {16'b0, (evicted ? fin.min_page : PAGE_BITS'(0))};

  // Control, fault total and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      fault_r     <= '0;
    end else begin
      if (accept) begin
        busy_r <= 1'b1;
      end else if (fin.vld) begin
        busy_r <= 1'b0;
      end
      out_valid_r <= fin.vld;
      fault_r     <= fault_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fin.vld) begin
      out_hit_r           <= hit;
      out_frame_index_r   <= slot_ext[3:0];
      out_evicted_valid_r <= evicted;
      out_evicted_page_r  <= ev_ext[15:0];
    end
  end

  assign busy              = busy_r;
  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_frame_index   = out_frame_index_r;
  assign out_evicted_valid = out_evicted_valid_r;
  assign out_evicted_page  = out_evicted_page_r;
  assign out_fault_total   = fault_r;

  `LFU_ASSERT_ALWAYS(a_one_token, !rst_n || $onehot0(tok_vlds), "more than one search token in flight")
  `LFU_ASSERT(a_start_busy, accept |=> busy_r, "busy not raised after accepted transaction")
  `LFU_ASSERT(a_strobe_busy, out_valid_r |-> $past(busy_r), "result strobe without busy")
  `LFU_ASSERT(a_hit_no_evict, out_valid_r |-> !(out_hit_r && out_evicted_valid_r), "hit with eviction")
  `LFU_ASSERT(a_fault_nonzero, (out_valid_r && !out_hit_r) |-> (fault_r != '0), "fault not counted")

endmodule

@@ test/tb_lfu_page_replacement_top.sv @@
`timescale 1ns / 1ps

module tb_lfu_page_replacement_top;
  import lfu_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = NUM_FRAMES + 8;
  localparam int PHASES = 15;
  localparam int PHASE_ITEMS = 60;
  localparam int POOL_MAX = 32;

  // One page-reference outcome
  typedef struct packed {
    logic                 hit;
    logic [IDX_W-1:0]     frame_index;
    logic                 evicted_valid;
    logic [PAGE_BITS-1:0] evicted_page;
    logic [FAULT_W-1:0]   fault_total;
  } lfu_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] in_page_number = '0;
  logic        out_valid;
  logic        out_hit;
  logic [3:0]  out_frame_index;
  logic        out_evicted_valid;
  logic [15:0] out_evicted_page;
  logic [31:0] out_fault_total;
  logic        cfg_we = 1'b0;
  logic [4:0]  cfg_wdata = '0;

  // Shadow copy of the frame table
  logic [PAGE_BITS-1:0] resident_page [NUM_FRAMES];
  logic                 resident_valid [NUM_FRAMES];
  logic [CNT_W-1:0]     use_cnt [NUM_FRAMES];
  logic [FAULT_W-1:0]   fault_cnt = '0;
  logic [CFG_W-1:0]     frames_cfg = 5'd16;

  lfu_result_t pending_results [$];
  int mismatch_count = 0;
  int cycle_count = 0;
  int burst_left = 0;

  logic [15:0] page_pool [POOL_MAX];
  int pool_size = 1;

  lfu_page_replacement_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_page_number    (in_page_number),
    .out_valid         (out_valid),
    .out_hit           (out_hit),
    .out_frame_index   (out_frame_index),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_fault_total   (out_fault_total),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run-away guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Out-of-range settings clamp to 1 .. NUM_FRAMES
  function automatic int active_frames(input logic [CFG_W-1:0] cfg);
    if (cfg == 0) return 1;
    if (cfg > NUM_FRAMES) return NUM_FRAMES;
    return int'(cfg);
  endfunction

  // LFU lookup / replacement; updates the shadow table
  function automatic lfu_result_t predict_reference(input logic [PAGE_BITS-1:0] page);
    int active;
    int slot;
    int f;
    bit found;
    bit have_empty;
    lfu_result_t r;
    active = active_frames(frames_cfg);
    slot = 0;
    found = 1'b0;
    have_empty = 1'b0;
    r = '0;
    // lowest-index valid match wins (duplicates possible after regrow)
    for (f = 0; f < active; f++)
      if (!found && resident_valid[f] && resident_page[f] == page) begin
        slot = f;
        found = 1'b1;
      end
    if (found) begin
      if (use_cnt[slot] != '1) use_cnt[slot]++;
    end else begin
      for (f = 0; f < active; f++)
        if (!have_empty && !resident_valid[f]) begin
          slot = f;
          have_empty = 1'b1;
        end
      // no free frame: smallest count, lowest index on ties
      if (!have_empty) begin
        slot = 0;
        for (f = 1; f < active; f++)
          if (use_cnt[f] < use_cnt[slot]) slot = f;
        r.evicted_valid = 1'b1;
        r.evicted_page = resident_page[slot];
      end
      resident_page[slot] = page;
      resident_valid[slot] = 1'b1;
      use_cnt[slot] = CNT_W'(1);
      if (fault_cnt != '1) fault_cnt++;
    end
    r.hit = found;
    r.frame_index = IDX_W'(slot);
    r.fault_total = fault_cnt;
    return r;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      mismatch_count++;
    end
  endtask

  // Result checker: every strobe is one transaction
  always @(posedge clk) begin : result_check
    lfu_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: no reference outstanding");
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("hit", want.hit, out_hit);
        check_field("frame_index", want.frame_index, out_frame_index);
        check_field("evicted_valid", want.evicted_valid, out_evicted_valid);
        check_field("evicted_page", want.evicted_page, out_evicted_page);
        check_field("fault_total", want.fault_total, out_fault_total);
      end
    end
  end

  // Present one page; returns at the edge that takes it, start left high
  task automatic issue_reference(input logic [15:0] page);
    in_page_number <= page;
    if (!start) start <= 1'b1;
    do @(posedge clk); while (busy);
    pending_results.push_back(predict_reference(page));
  endtask

  // Bursty sender: random gaps between bursts, some gaps zero
  task automatic sender_pause();
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 24);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Register writes only with the block idle
  task automatic write_frames_in_use(input logic [4:0] value);
    if (start) start <= 1'b0;
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    frames_cfg = value;
  endtask

  function automatic logic [15:0] pick_page();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 10) return 16'($urandom);
    if (sel < 50) return page_pool[$urandom_range(0, (pool_size < 3) ? pool_size - 1 : 2)];
    return page_pool[$urandom_range(0, pool_size - 1)];
  endfunction

  task automatic refill_pool();
    int i;
    for (i = 0; i < POOL_MAX; i++) begin
      case ($urandom_range(0, 15))
        0:       page_pool[i] = 16'h0000;
        1:       page_pool[i] = 16'hFFFF;
        default: page_pool[i] = 16'($urandom);
      endcase
    end
  endtask

  task automatic test_basic_hits();
    issue_reference(16'h0000);
    issue_reference(16'hFFFF);
    issue_reference(16'hFFFF);
    issue_reference(16'h0000);
  endtask

  // Zero acts as one frame, anything above 16 as 16
  task automatic test_register_limits();
    write_frames_in_use(5'd0);
    issue_reference(16'h1234);
    write_frames_in_use(5'd31);
    issue_reference(16'h1234);
    write_frames_in_use(5'd17);
    issue_reference(16'h8001);
  endtask

  // Shrink hides a page, reload puts a second copy low, regrow hits the lowest
  task automatic test_duplicate_residency();
    write_frames_in_use(5'd1);
    issue_reference(16'hFFFF);
    write_frames_in_use(5'd16);
    issue_reference(16'hFFFF);
  endtask

  // Equal counts evict the lower frame; hot frames survive
  task automatic test_tie_eviction();
    write_frames_in_use(5'd4);
    issue_reference(16'h5A5A);
    issue_reference(16'h0F0F);
    issue_reference(16'hF0F0);
    issue_reference(16'h5A5A);
    issue_reference(16'h5A5A);
    issue_reference(16'h3C3C);
  endtask

  // Working-set traffic over a sweep of frame counts
  task automatic test_random_traffic();
    logic [4:0] cfg_list [6];
    logic [4:0] cfg;
    int p;
    int i;
    cfg_list = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd2};
    refill_pool();
    for (p = 0; p < PHASES; p++) begin
      cfg = (p < 6) ? cfg_list[p] : 5'($urandom_range(0, 31));
      write_frames_in_use(cfg);
      // keeping the old pool across a resize provokes duplicate residency
      if ($urandom_range(0, 1)) refill_pool();
      pool_size = active_frames(cfg) + $urandom_range(0, 6);
      if (pool_size > POOL_MAX) pool_size = POOL_MAX;
      burst_left = $urandom_range(1, 12);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        issue_reference(pick_page());
        sender_pause();
      end
    end
  endtask

  initial begin
    for (int f = 0; f < NUM_FRAMES; f++) begin
      resident_page[f] = '0;
      resident_valid[f] = 1'b0;
      use_cnt[f] = '0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_basic_hits();
    test_register_limits();
    test_duplicate_residency();
    test_tie_eviction();
    test_random_traffic();

    start <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
